FILE: rtl/core/kt_pkg.sv
package kt_pkg;

  localparam int ENTRIES_DEF     = 5;
  localparam int IDENT_BYTES_DEF = 16;
  localparam int KEY_BYTES_DEF   = 16;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_NOP    = 2'd3
  } kt_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } kt_state_t;

endpackage

FILE: rtl/core/kt_store.sv
module kt_store
  import kt_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF,
  parameter int IW      = 3,
  parameter int DW      = 256
) (
  input  logic          clk,
  input  logic          we,
  input  logic [IW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [IW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/kt_ctrl.sv
module kt_ctrl
  import kt_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF,
  parameter int IW      = 3,
  parameter int IDW     = 128,
  parameter int KW      = 128
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        command,
  input  logic [IDW-1:0]    ident,
  input  logic [KW-1:0]     key_in,
  output logic              done,
  output logic              hit,
  output logic [KW-1:0]     key_out,
  output logic              we,
  output logic [IW-1:0]     waddr,
  output logic [IDW+KW-1:0] wdata,
  output logic              re,
  output logic [IW-1:0]     raddr,
  input  logic [IDW+KW-1:0] rdata
);

  localparam int CW = $clog2(ENTRIES + 1);

  kt_state_t         state, state_next;
  kt_cmd_t           cmd_r;
  logic [IDW-1:0]    ident_r;
  logic [KW-1:0]     key_r;
  logic [CW-1:0]     idx;
  logic              pend;
  logic [IW-1:0]     cmp_idx;
  logic              hit_r;
  logic [IW-1:0]     match_idx;
  logic [KW-1:0]     key_hit;
  logic [ENTRIES-1:0] valid;
  logic [IW-1:0]     ptr;
  logic              match;
  logic              last;

  assign match = pend && valid[cmp_idx] && (rdata[IDW+KW-1:KW] == ident_r);
  assign last  = pend && (cmp_idx == IW'(ENTRIES - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (start) state_next = ST_SCAN;
      ST_SCAN:   if (match || last) state_next = ST_FINISH;
      ST_FINISH: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy  = (state != ST_IDLE);
    re    = (state == ST_SCAN) && (idx != CW'(ENTRIES));
    raddr = idx[IW-1:0];
    we    = (state == ST_FINISH) && (cmd_r == CMD_ADD) && !hit_r;
    waddr = ptr;
    wdata = {ident_r, key_r};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      valid <= '0;
      ptr   <= '0;
      done  <= 1'b0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            cmd_r   <= kt_cmd_t'(command);
            ident_r <= ident;
            key_r   <= key_in;
            idx     <= '0;
            pend    <= 1'b0;
          end
        end
        ST_SCAN: begin
          pend    <= re;
          cmp_idx <= idx[IW-1:0];
          if (re) begin
            idx <= idx + CW'(1);
          end
          if (match) begin
            hit_r     <= 1'b1;
            match_idx <= cmp_idx;
            key_hit   <= rdata[KW-1:0];
          end else if (last) begin
            hit_r <= 1'b0;
          end
        end
        ST_FINISH: begin
          done <= 1'b1;
          hit  <= hit_r;
          key_out <= (cmd_r == CMD_LOOKUP && hit_r) ? key_hit : '0;
          if (cmd_r == CMD_ADD && !hit_r) begin
            valid[ptr] <= 1'b1;
            ptr <= (ptr == IW'(ENTRIES - 1)) ? '0 : ptr + IW'(1);
          end
          if (cmd_r == CMD_REMOVE && hit_r) begin
            valid[match_idx] <= 1'b0;
          end
        end
        default: begin
          pend <= 1'b0;
        end
      endcase
    end
  end

  a_done_after_finish: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_FINISH))
    else $error("result strobe without a finishing step");

  a_finish_to_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH) |=> (state == ST_IDLE))
    else $error("finishing step did not return to idle");

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    ptr <= IW'(ENTRIES - 1))
    else $error("replacement pointer out of range");

  a_remove_clears: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && cmd_r == CMD_REMOVE && hit_r) |=> !valid[$past(match_idx)])
    else $error("remove hit left entry valid");

endmodule

FILE: rtl/core/key_table_round_robin.sv
// Key table of ENTRIES identifier/key pairs with round-robin replacement. Pulse start
// with a command (add, lookup, remove) while busy is low; the table is walked one entry
// per cycle through a single registered read port and one shared identifier compare,
// stopping at the first valid match. The result appears on hit/key_out_* for exactly one
// cycle with done high, and sooner after start on an early hit than on a miss; the
// receiver cannot stall, so capture it on done. A new start is taken in the
// cycle done is shown. Only the low IDENT_BYTES and KEY_BYTES bytes are significant.
module key_table_round_robin
  import kt_pkg::*;
#(
  parameter int ENTRIES     = ENTRIES_DEF,
  parameter int IDENT_BYTES = IDENT_BYTES_DEF,
  parameter int KEY_BYTES   = KEY_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  command,
  input  logic [63:0] ident_high,
  input  logic [63:0] ident_low,
  input  logic [63:0] key_in_high,
  input  logic [63:0] key_in_low,
  output logic        done,
  output logic        hit,
  output logic [63:0] key_out_high,
  output logic [63:0] key_out_low
);

  localparam int IW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int IDW = 8 * IDENT_BYTES;
  localparam int KW  = 8 * KEY_BYTES;

  logic [127:0]      ident_full;
  logic [127:0]      key_full;
  logic [127:0]      key_out_full;
  logic [KW-1:0]     key_out_w;
  logic              we;
  logic [IW-1:0]     waddr;
  logic [IDW+KW-1:0] wdata;
  logic              re;
  logic [IW-1:0]     raddr;
  logic [IDW+KW-1:0] rdata;

  assign ident_full   = {ident_high, ident_low};
  assign key_full     = {key_in_high, key_in_low};
  assign key_out_full = 128'(key_out_w);
  assign key_out_high = key_out_full[127:64];
  assign key_out_low  = key_out_full[63:0];

  kt_ctrl #(
    .ENTRIES (ENTRIES),
    .IW      (IW),
    .IDW     (IDW),
    .KW      (KW)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .command (command),
    .ident   (ident_full[IDW-1:0]),
    .key_in  (key_full[KW-1:0]),
    .done    (done),
    .hit     (hit),
    .key_out (key_out_w),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .re      (re),
    .raddr   (raddr),
    .rdata   (rdata)
  );

  kt_store #(
    .ENTRIES (ENTRIES),
    .IW      (IW),
    .DW      (IDW + KW)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

endmodule

FILE: bench/key_table_round_robin_tb.sv
`timescale 1ns / 100ps

module key_table_round_robin_tb;
  import kt_pkg::*;

  localparam int STALL_LIMIT = 400;
  localparam int POOL_SIZE = 8;
  localparam logic [63:0] ALL_ONES = '1;
  localparam logic [63:0] IDENT_MASK_LOW = (IDENT_BYTES_DEF >= 8) ? ALL_ONES :
      ((64'd1 << (8 * IDENT_BYTES_DEF)) - 64'd1);
  localparam logic [63:0] IDENT_MASK_HIGH = (IDENT_BYTES_DEF <= 8) ? 64'd0 :
      (IDENT_BYTES_DEF >= 16) ? ALL_ONES : ((64'd1 << (8 * (IDENT_BYTES_DEF - 8))) - 64'd1);
  localparam logic [63:0] KEY_MASK_LOW = (KEY_BYTES_DEF >= 8) ? ALL_ONES :
      ((64'd1 << (8 * KEY_BYTES_DEF)) - 64'd1);
  localparam logic [63:0] KEY_MASK_HIGH = (KEY_BYTES_DEF <= 8) ? 64'd0 :
      (KEY_BYTES_DEF >= 16) ? ALL_ONES : ((64'd1 << (8 * (KEY_BYTES_DEF - 8))) - 64'd1);

  typedef struct packed {
    logic        hit;
    logic [63:0] key_high;
    logic [63:0] key_low;
  } table_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  command = CMD_NOP;
  logic [63:0] ident_high = '0;
  logic [63:0] ident_low = '0;
  logic [63:0] key_in_high = '0;
  logic [63:0] key_in_low = '0;
  logic        done;
  logic        hit;
  logic [63:0] key_out_high;
  logic [63:0] key_out_low;

  logic        table_valid [ENTRIES_DEF] = '{default: 1'b0};
  logic [63:0] table_ident_high [ENTRIES_DEF];
  logic [63:0] table_ident_low [ENTRIES_DEF];
  logic [63:0] table_key_high [ENTRIES_DEF];
  logic [63:0] table_key_low [ENTRIES_DEF];
  int          add_slot = 0;

  table_result_t expected_results [$];
  table_result_t oldest_result;
  int          mismatch_count = 0;
  int          quiet_cycles = 0;

  logic [63:0] pool_high [POOL_SIZE];
  logic [63:0] pool_low [POOL_SIZE];

  key_table_round_robin DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .ident_high   (ident_high),
    .ident_low    (ident_low),
    .key_in_high  (key_in_high),
    .key_in_low   (key_in_low),
    .done         (done),
    .hit          (hit),
    .key_out_high (key_out_high),
    .key_out_low  (key_out_low)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic table_result_t predict_table(kt_cmd_t cmd, logic [63:0] ih_raw,
                                                  logic [63:0] il_raw, logic [63:0] kh_raw,
                                                  logic [63:0] kl_raw);
    logic [63:0]   ih;
    logic [63:0]   il;
    int            match;
    table_result_t res;
    ih = ih_raw & IDENT_MASK_HIGH;
    il = il_raw & IDENT_MASK_LOW;
    match = ENTRIES_DEF;
    for (int i = ENTRIES_DEF - 1; i >= 0; i--) begin
      if (table_valid[i] && table_ident_high[i] == ih && table_ident_low[i] == il) begin
        match = i;
      end
    end
    res.hit = (match < ENTRIES_DEF);
    res.key_high = '0;
    res.key_low = '0;
    case (cmd)
      CMD_ADD: begin
        if (!res.hit) begin
          table_ident_high[add_slot] = ih;
          table_ident_low[add_slot] = il;
          table_key_high[add_slot] = kh_raw & KEY_MASK_HIGH;
          table_key_low[add_slot] = kl_raw & KEY_MASK_LOW;
          table_valid[add_slot] = 1'b1;
          add_slot = (add_slot >= ENTRIES_DEF - 1) ? 0 : add_slot + 1;
        end
      end
      CMD_LOOKUP: begin
        if (res.hit) begin
          res.key_high = table_key_high[match];
          res.key_low = table_key_low[match];
        end
      end
      CMD_REMOVE: begin
        if (res.hit) table_valid[match] = 1'b0;
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic issue_command(input kt_cmd_t cmd, input logic [63:0] ih, input logic [63:0] il,
                               input logic [63:0] kh, input logic [63:0] kl);
    command = cmd;
    ident_high = ih;
    ident_low = il;
    key_in_high = kh;
    key_in_low = kl;
    start = 1'b1;
    // hold the word until busy drops
    do @(posedge clk); while (busy);
    expected_results.push_back(predict_table(cmd, ih, il, kh, kl));
    @(negedge clk);
  endtask

  task automatic pause_sender(input int cycles);
    start = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch: %s", what);
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result with none expected: hit %0b key %h_%h",
                                  hit, key_out_high, key_out_low));
      end else begin
        oldest_result = expected_results.pop_front();
        if (hit !== oldest_result.hit)
          report_mismatch($sformatf("hit expected %0b got %0b", oldest_result.hit, hit));
        if (key_out_high !== oldest_result.key_high)
          report_mismatch($sformatf("key_out_high expected %h got %h",
                                    oldest_result.key_high, key_out_high));
        if (key_out_low !== oldest_result.key_low)
          report_mismatch($sformatf("key_out_low expected %h got %h",
                                    oldest_result.key_low, key_out_low));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  localparam logic [63:0] ID_A_HIGH = 64'h0123_4567_89ab_cdef;
  localparam logic [63:0] ID_A_LOW  = 64'hfedc_ba98_7654_3210;
  localparam logic [63:0] ID_B_HIGH = 64'h5a5a_a5a5_0f0f_f0f0;
  localparam logic [63:0] ID_B_LOW  = 64'h1111_2222_3333_4444;

  task automatic test_empty_table();
    issue_command(CMD_LOOKUP, ID_A_HIGH, ID_A_LOW, rand64(), rand64());
    issue_command(CMD_REMOVE, ID_A_HIGH, ID_A_LOW, rand64(), rand64());
    issue_command(CMD_NOP, ID_A_HIGH, ID_A_LOW, rand64(), rand64());
  endtask

  task automatic test_add_lookup_remove();
    issue_command(CMD_ADD, ID_A_HIGH, ID_A_LOW, 64'hdead_beef_0000_0001, 64'hcafe_f00d_1234_5678);
    issue_command(CMD_LOOKUP, ID_A_HIGH, ID_A_LOW, rand64(), rand64());
    issue_command(CMD_ADD, ID_A_HIGH, ID_A_LOW, 64'h7777_8888_9999_aaaa, 64'hbbbb_cccc_dddd_eeee);
    issue_command(CMD_LOOKUP, ID_A_HIGH, ID_A_LOW, rand64(), rand64());
    issue_command(CMD_REMOVE, ID_A_HIGH, ID_A_LOW, rand64(), rand64());
    issue_command(CMD_LOOKUP, ID_A_HIGH, ID_A_LOW, rand64(), rand64());
    issue_command(CMD_REMOVE, ID_A_HIGH, ID_A_LOW, rand64(), rand64());
  endtask

  task automatic test_unused_command();
    issue_command(CMD_ADD, ID_B_HIGH, ID_B_LOW, rand64(), rand64());
    issue_command(CMD_NOP, ID_B_HIGH, ID_B_LOW, rand64(), rand64());
  endtask

  task automatic test_extreme_values();
    issue_command(CMD_ADD, ALL_ONES, ALL_ONES, '0, '0);
    issue_command(CMD_ADD, '0, '0, ALL_ONES, ALL_ONES);
    issue_command(CMD_LOOKUP, ALL_ONES, ALL_ONES, rand64(), rand64());
    issue_command(CMD_LOOKUP, '0, '0, rand64(), rand64());
    issue_command(CMD_LOOKUP, ALL_ONES, '0, rand64(), rand64());
  endtask

  task automatic test_round_robin_overwrite();
    issue_command(CMD_ADD, rand64(), rand64(), rand64(), rand64());
    issue_command(CMD_ADD, rand64(), rand64(), rand64(), rand64());
    issue_command(CMD_ADD, ID_A_HIGH, ID_B_LOW, rand64(), rand64());
    issue_command(CMD_LOOKUP, ID_B_HIGH, ID_B_LOW, rand64(), rand64());
    issue_command(CMD_LOOKUP, ID_A_HIGH, ID_B_LOW, rand64(), rand64());
    issue_command(CMD_LOOKUP, ALL_ONES, ALL_ONES, rand64(), rand64());
  endtask

  task automatic test_random_traffic(input int count, input bit with_idle);
    int          pick;
    int          other;
    int          roll;
    kt_cmd_t     cmd;
    logic [63:0] ih;
    logic [63:0] il;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 3) begin
        pick = $urandom_range(0, POOL_SIZE - 1);
        other = $urandom_range(0, POOL_SIZE - 1);
        case ($urandom_range(0, 2))
          0: begin
            pool_high[pick] = pool_high[other];
            pool_low[pick] = rand64();
          end
          1: begin
            pool_high[pick] = rand64();
            pool_low[pick] = pool_low[other];
          end
          default: begin
            pool_high[pick] = rand64();
            pool_low[pick] = rand64();
          end
        endcase
      end
      roll = $urandom_range(0, 99);
      if (roll < 35) cmd = CMD_ADD;
      else if (roll < 70) cmd = CMD_LOOKUP;
      else if (roll < 90) cmd = CMD_REMOVE;
      else cmd = CMD_NOP;
      if ($urandom_range(0, 99) < 85) begin
        pick = $urandom_range(0, POOL_SIZE - 1);
        ih = pool_high[pick];
        il = pool_low[pick];
      end else begin
        ih = rand64();
        il = rand64();
      end
      issue_command(cmd, ih, il, rand64(), rand64());
      if (with_idle && $urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 12));
    end
  endtask

  initial begin
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_high[i] = rand64();
      pool_low[i] = rand64();
    end
    repeat (9) @(negedge clk);
    rst = 1'b0;
    test_empty_table();
    test_add_lookup_remove();
    test_unused_command();
    test_extreme_values();
    test_round_robin_overwrite();
    test_random_traffic(1500, 1'b1);
    test_random_traffic(200, 1'b0);
    start = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (ENTRIES_DEF + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: key_table_round_robin.f
rtl/core/kt_pkg.sv
rtl/core/kt_store.sv
rtl/core/kt_ctrl.sv
rtl/core/key_table_round_robin.sv
bench/key_table_round_robin_tb.sv
